// ===== rtl/tiir_pkg.sv =====
// ----------------------------------------------------------------------------
// tiir_pkg: shared types and constants for the third-order IIR low-pass
// Coefficient format, register indexes and reset coefficient values.
// ----------------------------------------------------------------------------
package tiir_pkg;

    localparam int COEF_W    = 16;
    localparam int NUM_REGS  = 7;
    localparam int REG_IDX_W = 3;
    localparam int NUM_TAPS  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_3 = 3'd6;

    typedef logic signed [COEF_W-1:0] t_coef;

    // coefficient pair used by one delay tap
    typedef struct packed {
        t_coef ff;
        t_coef fb;
    } t_tap_coef;

    localparam t_coef FF_COEF_0_RST = 16'sd762;
    localparam t_coef FF_COEF_1_RST = 16'sd2289;
    localparam t_coef FF_COEF_2_RST = 16'sd2289;
    localparam t_coef FF_COEF_3_RST = 16'sd762;
    localparam t_coef FB_COEF_1_RST = 16'sd19735;
    localparam t_coef FB_COEF_2_RST = -16'sd11870;
    localparam t_coef FB_COEF_3_RST = 16'sd2387;

endpackage

// ===== rtl/tiir_if.sv =====
// ----------------------------------------------------------------------------
// tiir_if: channel interfaces for the third-order IIR low-pass
// Input sample, output sample and coefficient write channels.
// ----------------------------------------------------------------------------
interface tiir_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface tiir_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface tiir_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tiir_pkg::REG_IDX_W-1:0]   index;
    logic [tiir_pkg::COEF_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tiir_tap_cell.sv =====
// ----------------------------------------------------------------------------
// tiir_tap_cell: one delay tap of the filter
// Holds one past input and one past output, weights both and adds them to
// the running sum; shifts its samples on to the next cell on each word.
// ----------------------------------------------------------------------------
module tiir_tap_cell #(
    parameter int SW = 16,
    parameter int AW = 35
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic signed [SW-1:0]        i_x,
    input  logic signed [SW-1:0]        i_y,
    input  tiir_pkg::t_tap_coef         i_coef,
    input  logic signed [AW-1:0]        i_sum,
    output logic signed [SW-1:0]        o_x,
    output logic signed [SW-1:0]        o_y,
    output logic signed [AW-1:0]        o_sum
);
    import tiir_pkg::*;

    logic signed [SW-1:0]        r_x;
    logic signed [SW-1:0]        r_y;
    logic signed [SW+COEF_W-1:0] prod_ff;
    logic signed [SW+COEF_W-1:0] prod_fb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_adv) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign prod_ff = r_x * i_coef.ff;
    assign prod_fb = r_y * i_coef.fb;
    assign o_sum   = i_sum + AW'(prod_ff) + AW'(prod_fb);
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

// ===== rtl/tiir_round_sat.sv =====
// ----------------------------------------------------------------------------
// tiir_round_sat: output rounding and saturation
// Round half up by the coefficient fraction, clamp to the sample range.
// ----------------------------------------------------------------------------
module tiir_round_sat #(
    parameter int SW = 16,
    parameter int AW = 35,
    parameter int FB = 14
) (
    input  logic signed [AW-1:0] i_acc,
    output logic signed [SW-1:0] o_y,
    output logic                 o_clip
);
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FB - 1);
    localparam logic signed [AW-1:0] HI   = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] LO   = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] shf;

    assign rnd = i_acc + HALF;
    assign shf = rnd >>> FB;

    always_comb begin
        if (shf > HI) begin
            o_y    = HI[SW-1:0];
            o_clip = 1'b1;
        end else if (shf < LO) begin
            o_y    = LO[SW-1:0];
            o_clip = 1'b1;
        end else begin
            o_y    = shf[SW-1:0];
            o_clip = 1'b0;
        end
    end

endmodule

// ===== rtl/third_order_iir_lowpass_top.sv =====
// ----------------------------------------------------------------------------
// third_order_iir_lowpass_top: third-order direct-form-I IIR low-pass
// Current-input product plus a row of three tap cells, rounding and
// saturation, registered output word.
//
//  channel   dir  handshake     payload
//  i_samp    in   valid/ready   sample_in
//  o_samp    out  valid/ready   sample_out, clipped
//  i_cfg     in   valid/ready   index, data (ready always high)
//
// One word per cycle while o_samp is ready; result appears the cycle after
// acceptance. The feedback sum through the three tap cells is combinational.
// Synchronous active-low reset loads default coefficients and clears both
// delay lines. Input ready drops only while a result waits on o_samp.
// ----------------------------------------------------------------------------
module third_order_iir_lowpass_top #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tiir_in_if.sink    i_samp,
    tiir_out_if.source o_samp,
    tiir_cfg_if.sink   i_cfg
);
    import tiir_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = SAMPLE_WIDTH + COEF_W + 3;

    t_coef r_ff [0:NUM_TAPS];
    t_coef r_fb [1:NUM_TAPS];

    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_clip;

    logic                        in_acc;
    logic                        cfg_acc;
    logic signed [SW+COEF_W-1:0] prod0;
    logic signed [SW-1:0]        x_chain   [0:NUM_TAPS];
    logic signed [SW-1:0]        y_chain   [0:NUM_TAPS];
    logic signed [AW-1:0]        sum_chain [0:NUM_TAPS];
    logic signed [SW-1:0]        y_new;
    logic                        clip_new;

    assign i_samp.ready = !r_out_valid || o_samp.ready;
    assign in_acc       = i_samp.valid && i_samp.ready;
    assign i_cfg.ready  = 1'b1;
    assign cfg_acc      = i_cfg.valid && i_cfg.ready;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff[0] <= FF_COEF_0_RST;
            r_ff[1] <= FF_COEF_1_RST;
            r_ff[2] <= FF_COEF_2_RST;
            r_ff[3] <= FF_COEF_3_RST;
            r_fb[1] <= FB_COEF_1_RST;
            r_fb[2] <= FB_COEF_2_RST;
            r_fb[3] <= FB_COEF_3_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                REG_FF_COEF_0: r_ff[0] <= i_cfg.data;
                REG_FF_COEF_1: r_ff[1] <= i_cfg.data;
                REG_FF_COEF_2: r_ff[2] <= i_cfg.data;
                REG_FF_COEF_3: r_ff[3] <= i_cfg.data;
                REG_FB_COEF_1: r_fb[1] <= i_cfg.data;
                REG_FB_COEF_2: r_fb[2] <= i_cfg.data;
                REG_FB_COEF_3: r_fb[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign prod0        = i_samp.sample_in * r_ff[0];
    assign x_chain[0]   = i_samp.sample_in;
    assign y_chain[0]   = y_new;
    assign sum_chain[0] = AW'(prod0);

    for (genvar k = 1; k <= NUM_TAPS; k++) begin : g_tap
        t_tap_coef tap_coef;
        assign tap_coef.ff = r_ff[k];
        assign tap_coef.fb = r_fb[k];

        tiir_tap_cell #(
            .SW (SW),
            .AW (AW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (in_acc),
            .i_x     (x_chain[k-1]),
            .i_y     (y_chain[k-1]),
            .i_coef  (tap_coef),
            .i_sum   (sum_chain[k-1]),
            .o_x     (x_chain[k]),
            .o_y     (y_chain[k]),
            .o_sum   (sum_chain[k])
        );
    end

    tiir_round_sat #(
        .SW (SW),
        .AW (AW),
        .FB (COEF_FRAC_BITS)
    ) u_round_sat (
        .i_acc  (sum_chain[NUM_TAPS]),
        .o_y    (y_new),
        .o_clip (clip_new)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_samp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_sample <= y_new;
            r_out_clip   <= clip_new;
        end
    end

    assign o_samp.valid      = r_out_valid;
    assign o_samp.sample_out = r_out_sample;
    assign o_samp.clipped    = r_out_clip;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    a_acc_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_samp.valid)
        else $error("accepted word produced no result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_samp.valid && !o_samp.ready) |-> !in_acc)
        else $error("input accepted over a stalled result");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_samp.valid && o_samp.clipped) |->
            (o_samp.sample_out == SMAX || o_samp.sample_out == SMIN))
        else $error("clipped result not at a rail");

    a_cfg_ff0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_acc && i_cfg.index == REG_FF_COEF_0) |=> r_ff[0] == $past(i_cfg.data))
        else $error("coefficient write lost");

endmodule
